>>> rtl/core/rc_pkg.sv
package rc_pkg;

   localparam int REL_DEPTH = 8;
   localparam int ELEM_BITS = 16;
   localparam int FOUND_MAX = REL_DEPTH * REL_DEPTH;

   localparam int REL_IDX_BITS   = (REL_DEPTH > 1) ? $clog2(REL_DEPTH) : 1;
   localparam int REL_CNT_BITS   = $clog2(REL_DEPTH + 1);
   localparam int FOUND_IDX_BITS = (FOUND_MAX > 1) ? $clog2(FOUND_MAX) : 1;
   localparam int FOUND_CNT_BITS = $clog2(FOUND_MAX + 1);

   localparam logic [1:0] CMD_CLEAR       = 2'd0;
   localparam logic [1:0] CMD_LOAD_FIRST  = 2'd1;
   localparam logic [1:0] CMD_LOAD_SECOND = 2'd2;
   localparam logic [1:0] CMD_COMPOSE     = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_PAIR  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef logic [ELEM_BITS-1:0]    elem_type;
   typedef logic [REL_IDX_BITS-1:0] rel_idx_type;
   typedef logic [REL_CNT_BITS-1:0] rel_cnt_type;

   typedef struct packed {
      elem_type first;
      elem_type second;
   } pair_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] left_value;
      logic signed [15:0] right_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] pair_first;
      logic signed [15:0] pair_second;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic search;
      logic add;
   } found_ctl_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } found_stat_type;

   function automatic elem_type load_elem(input logic [15:0] raw);
      logic [31:0] w;
      w = {{16{raw[15]}}, raw};
      return w[ELEM_BITS-1:0];
   endfunction

   function automatic logic [15:0] out_elem(input elem_type v);
      logic [31:0] w;
      w = 32'(signed'(v));
      return w[15:0];
   endfunction

endpackage

>>> rtl/core/rc_rel_store.sv
module rc_rel_store
   import rc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        wr_en,
   input  pair_type    wr_pair,
   input  rel_idx_type rd_addr,
   output pair_type    rd_pair,
   output rel_cnt_type count,
   output logic        full
);

   pair_type    rel_ff [REL_DEPTH];
   rel_cnt_type count_ff;
   rel_cnt_type count_in;
   logic        write_ok;

   assign full     = (count_ff == rel_cnt_type'(REL_DEPTH));
   assign write_ok = wr_en && !full && !clear;
   assign count    = count_ff;
   assign rd_pair  = rel_ff[rd_addr];

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (write_ok) begin
         count_in = count_ff + rel_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_ok) begin
         rel_ff[count_ff[REL_IDX_BITS-1:0]] <= wr_pair;
      end
   end

endmodule

>>> rtl/core/rc_found.sv
module rc_found
   import rc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  found_ctl_type  ctl,
   input  pair_type       key,
   output found_stat_type stat
);

   typedef logic [FOUND_CNT_BITS-1:0] fcnt_type;

   pair_type mem [FOUND_MAX];
   pair_type rd_data_ff;

   fcnt_type cnt_ff, cnt_in;
   fcnt_type k_ff, k_in;
   logic     issue_ff, issue_in;
   logic     rd_vld_ff, rd_vld_in;
   logic     rd_last_ff, rd_last_in;
   logic     done_ff, done_in;
   logic     hit_ff, hit_in;
   logic     full;
   logic     k_last;

   assign full   = (cnt_ff == fcnt_type'(FOUND_MAX));
   assign k_last = ((k_ff + fcnt_type'(1)) == cnt_ff);
   assign stat   = '{done: done_ff, hit: hit_ff, full: full};

   always_comb begin
      cnt_in     = cnt_ff;
      k_in       = k_ff;
      issue_in   = issue_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      done_in    = 1'b0;
      hit_in     = 1'b0;

      if (ctl.clear) begin
         cnt_in = '0;
      end else if (ctl.add && !full) begin
         cnt_in = cnt_ff + fcnt_type'(1);
      end

      if (ctl.search) begin
         if (cnt_ff == '0) begin
            done_in = 1'b1;
         end else begin
            issue_in = 1'b1;
            k_in     = '0;
         end
      end

      // one entry read per cycle, compared in the next cycle
      if (issue_ff) begin
         k_in       = k_ff + fcnt_type'(1);
         rd_vld_in  = 1'b1;
         rd_last_in = k_last;
         if (k_last) begin
            issue_in = 1'b0;
         end
      end

      if (rd_vld_ff) begin
         if (rd_data_ff == key) begin
            done_in   = 1'b1;
            hit_in    = 1'b1;
            issue_in  = 1'b0;
            rd_vld_in = 1'b0;
         end else if (rd_last_ff) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         k_ff       <= '0;
         issue_ff   <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         k_ff       <= k_in;
         issue_ff   <= issue_in;
         rd_vld_ff  <= rd_vld_in;
         rd_last_ff <= rd_last_in;
         done_ff    <= done_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add && !full) begin
         mem[cnt_ff[FOUND_IDX_BITS-1:0]] <= key;
      end
      if (issue_ff) begin
         rd_data_ff <= mem[k_ff[FOUND_IDX_BITS-1:0]];
      end
   end

endmodule

>>> rtl/core/relation_composition.sv
// channel | ports                              | direction | item
// req     | req_valid, req_ready, req_data     | in        | cmd, left_value, right_value
// rsp     | rsp_valid, rsp_ready, rsp_data     | out       | status, pair_first, pair_second, last
// csr     | csr_wr_en, csr_wr_data             | in        | order_swap, no wait
//
// clear and load give one item through the output register
// compose walks all left x right pairs, one pair a cycle where pairs do not
// join; each match scans the found-pair memory one entry a cycle
// results are held back one deep so the final one can carry last
// synchronous reset clears counts, sequencer and order_swap; a stalled rsp holds
// the walk, and req_ready stays low until the compose has finished
module relation_composition
   import rc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PAIR   = 5'b00010,
      ST_SEARCH = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   rel_idx_type i_ff, i_in;
   rel_idx_type j_ff, j_in;
   rel_cnt_type ln_ff, ln_in;
   rel_cnt_type rn_ff, rn_in;
   pair_type    cand_ff, cand_in;
   pair_type    held_ff, held_in;
   logic        held_vld_ff, held_vld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        swap_ff;

   logic        req_accept;
   logic        out_free;
   logic        advance;
   logic        j_end;
   logic        i_end;
   logic        rel_clear;
   logic        first_wr, second_wr;
   pair_type    load_pair;

   rel_idx_type    first_addr, second_addr;
   pair_type       first_pair, second_pair;
   rel_cnt_type    first_cnt, second_cnt;
   logic           first_full, second_full;
   pair_type       left_pair, right_pair;
   rel_cnt_type    left_cnt, right_cnt;
   found_ctl_type  fctl;
   found_stat_type fstat;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign load_pair   = '{first:  load_elem(req_data.left_value),
                          second: load_elem(req_data.right_value)};
   assign first_addr  = swap_ff ? j_ff : i_ff;
   assign second_addr = swap_ff ? i_ff : j_ff;
   assign left_pair   = swap_ff ? second_pair : first_pair;
   assign right_pair  = swap_ff ? first_pair : second_pair;
   assign left_cnt    = swap_ff ? second_cnt : first_cnt;
   assign right_cnt   = swap_ff ? first_cnt : second_cnt;

   assign j_end = ((rel_cnt_type'(j_ff) + rel_cnt_type'(1)) == rn_ff);
   assign i_end = ((rel_cnt_type'(i_ff) + rel_cnt_type'(1)) == ln_ff);

   rc_rel_store u_first (
      .clock   (clock),
      .reset   (reset),
      .clear   (rel_clear),
      .wr_en   (first_wr),
      .wr_pair (load_pair),
      .rd_addr (first_addr),
      .rd_pair (first_pair),
      .count   (first_cnt),
      .full    (first_full)
   );

   rc_rel_store u_second (
      .clock   (clock),
      .reset   (reset),
      .clear   (rel_clear),
      .wr_en   (second_wr),
      .wr_pair (load_pair),
      .rd_addr (second_addr),
      .rd_pair (second_pair),
      .count   (second_cnt),
      .full    (second_full)
   );

   rc_found u_found (
      .clock (clock),
      .reset (reset),
      .ctl   (fctl),
      .key   (cand_ff),
      .stat  (fstat)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ln_in        = ln_ff;
      rn_in        = rn_ff;
      cand_in      = cand_ff;
      held_in      = held_ff;
      held_vld_in  = held_vld_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;
      advance      = 1'b0;
      rel_clear    = 1'b0;
      first_wr     = 1'b0;
      second_wr    = 1'b0;
      fctl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_OK, pair_first: '0, pair_second: '0,
                                last: 1'b1};
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     rel_clear = 1'b1;
                  end
                  CMD_LOAD_FIRST: begin
                     first_wr = 1'b1;
                     if (first_full) begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  CMD_LOAD_SECOND: begin
                     second_wr = 1'b1;
                     if (second_full) begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  CMD_COMPOSE: begin
                     if (left_cnt == '0 || right_cnt == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
                        rsp_in       = rsp_ff;
                        ln_in        = left_cnt;
                        rn_in        = right_cnt;
                        i_in         = '0;
                        j_in         = '0;
                        held_vld_in  = 1'b0;
                        fctl.clear   = 1'b1;
                        state_in     = ST_PAIR;
                     end
                  end
                  default: begin
                     rsp_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_PAIR: begin
            if (left_pair.second == right_pair.first) begin
               cand_in     = '{first: left_pair.first, second: right_pair.second};
               fctl.search = 1'b1;
               state_in    = ST_SEARCH;
            end else begin
               advance = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (fstat.done) begin
               if (fstat.hit) begin
                  advance = 1'b1;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (fstat.full) begin
               advance = 1'b1;
            end else if (!held_vld_ff) begin
               held_in     = cand_ff;
               held_vld_in = 1'b1;
               fctl.add    = 1'b1;
               advance     = 1'b1;
            end else if (out_free) begin
               // pass the held pair on, the new one waits in its place
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_PAIR,
                                pair_first: out_elem(held_ff.first),
                                pair_second: out_elem(held_ff.second),
                                last: 1'b0};
               held_in      = cand_ff;
               fctl.add     = 1'b1;
               advance      = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (held_vld_ff) begin
                  rsp_in = '{status: STATUS_PAIR,
                             pair_first: out_elem(held_ff.first),
                             pair_second: out_elem(held_ff.second),
                             last: 1'b1};
               end else begin
                  rsp_in = '{status: STATUS_EMPTY, pair_first: '0, pair_second: '0,
                             last: 1'b1};
               end
               held_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (j_end) begin
            j_in = '0;
            i_in = i_ff + rel_idx_type'(1);
         end else begin
            j_in = j_ff + rel_idx_type'(1);
         end
         state_in = (j_end && i_end) ? ST_FLUSH : ST_PAIR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         ln_ff        <= '0;
         rn_ff        <= '0;
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         ln_ff        <= ln_in;
         rn_ff        <= rn_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            swap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   // nothing is left held back once the block is idle again
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !held_vld_ff)
      else $error("held pair left over in idle");

   // the found-pair scan only reports while the sequencer waits for it
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      fstat.done |-> state_ff == ST_SEARCH)
      else $error("found-pair scan finished outside search");

   // walk indices stay inside the latched relation sizes
   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAIR |->
         (rel_cnt_type'(i_ff) < ln_ff) && (rel_cnt_type'(j_ff) < rn_ff))
      else $error("compose walk index out of range");

   // every non-pair result ends its item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_PAIR |-> rsp_ff.last)
      else $error("single result without last");

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rc_pkg::*;

   // keeps its own copy of both relations and the ordering bit, and holds the
   // items that the block owes
   class composition_checker;
      pair_type first_rel[$];
      pair_type second_rel[$];
      logic order_swap = 1'b0;
      rsp_type pending_results[$];
      int mismatches = 0;
      int checked = 0;
      int pair_hits = 0;
      int empty_sets = 0;
      int dropped = 0;

      task report_error(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      function void set_order(logic value);
         order_swap = value;
      endfunction

      // a loaded element keeps its low ELEM_BITS bits
      function elem_type narrow(logic signed [15:0] raw);
         logic signed [31:0] w;
         w = 32'(raw);
         return w[ELEM_BITS-1:0];
      endfunction

      // sign-extend from ELEM_BITS and cut to the port width
      function logic [15:0] widen(elem_type v);
         logic signed [31:0] w;
         w = 32'(signed'(v));
         return w[15:0];
      endfunction

      function void push_result(logic [1:0] status, elem_type a, elem_type c);
         rsp_type r;
         r.status = status;
         r.pair_first = widen(a);
         r.pair_second = widen(c);
         r.last = 1'b0;
         pending_results = {pending_results, r};
      endfunction

      function void predict_composition();
         pair_type lhs[$];
         pair_type rhs[$];
         pair_type found[$];
         pair_type hit;
         bit seen;
         if (order_swap) begin
            lhs = second_rel;
            rhs = first_rel;
         end else begin
            lhs = first_rel;
            rhs = second_rel;
         end
         foreach (lhs[i]) begin
            foreach (rhs[j]) begin
               if (lhs[i].second == rhs[j].first) begin
                  hit.first = lhs[i].first;
                  hit.second = rhs[j].second;
                  seen = 1'b0;
                  foreach (found[k]) begin
                     if (found[k] == hit) seen = 1'b1;
                  end
                  if (!seen) begin
                     found = {found, hit};
                     push_result(STATUS_PAIR, hit.first, hit.second);
                  end
               end
            end
         end
         if (found.size() == 0) push_result(STATUS_EMPTY, '0, '0);
      endfunction

      function void note_request(req_type item);
         pair_type p;
         bit full;
         p.first = narrow(item.left_value);
         p.second = narrow(item.right_value);
         case (item.cmd)
            CMD_CLEAR: begin
               first_rel.delete();
               second_rel.delete();
               push_result(STATUS_OK, '0, '0);
            end
            CMD_LOAD_FIRST, CMD_LOAD_SECOND: begin
               if (item.cmd == CMD_LOAD_FIRST) full = first_rel.size() >= REL_DEPTH;
               else full = second_rel.size() >= REL_DEPTH;
               if (full) begin
                  push_result(STATUS_FULL, '0, '0);
               end else begin
                  if (item.cmd == CMD_LOAD_FIRST) first_rel = {first_rel, p};
                  else second_rel = {second_rel, p};
                  push_result(STATUS_OK, '0, '0);
               end
            end
            default: predict_composition();
         endcase
         pending_results[pending_results.size()-1].last = 1'b1;
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_error($sformatf("unexpected item, status %0d", got.status));
            return;
         end
         want = pending_results.pop_front();
         checked++;
         if (got.status !== want.status)
            report_error($sformatf("status %0d, wanted %0d", got.status, want.status));
         if (got.pair_first !== want.pair_first)
            report_error($sformatf("pair_first %0d, wanted %0d", got.pair_first,
                                   want.pair_first));
         if (got.pair_second !== want.pair_second)
            report_error($sformatf("pair_second %0d, wanted %0d", got.pair_second,
                                   want.pair_second));
         if (got.last !== want.last)
            report_error($sformatf("last %0b, wanted %0b", got.last, want.last));
         case (want.status)
            STATUS_PAIR: pair_hits++;
            STATUS_EMPTY: empty_sets++;
            STATUS_FULL: dropped++;
            default: ;
         endcase
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   int req_idle_pct = 14;
   int rsp_idle_pct = 61;
   int items_sent = 0;

   composition_checker board = new;

   relation_composition i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   function automatic req_type make_item(logic [1:0] cmd, logic [15:0] lhs,
                                         logic [15:0] rhs);
      req_type item;
      item.cmd = cmd;
      item.left_value = lhs;
      item.right_value = rhs;
      return item;
   endfunction

   // entered and left at a falling edge; valid stays up for a following item
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_order(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_order(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic directed_items();
      logic [15:0] heads [8];
      logic [15:0] tails [8];
      logic [15:0] link;
      heads = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                16'h0064};
      tails = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0002, 16'h0003, 16'h00FF,
                16'h7F00};
      link = 16'h0007;
      send_item(make_item(CMD_COMPOSE, '0, '0));
      send_item(make_item(CMD_LOAD_FIRST, 16'h8000, 16'h7FFF));
      // second relation still empty
      send_item(make_item(CMD_COMPOSE, '0, '0));
      send_item(make_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF));
      // fill both stores, the ninth load of each is dropped
      for (int i = 0; i <= REL_DEPTH; i++)
         send_item(make_item(CMD_LOAD_FIRST, heads[i % REL_DEPTH], link));
      for (int i = 0; i <= REL_DEPTH; i++)
         send_item(make_item(CMD_LOAD_SECOND, link, tails[i % REL_DEPTH]));
      // every pair meets on the link value: the full 8 x 8 result set
      send_item(make_item(CMD_COMPOSE, '0, '0));
      settle();
      // swapped, four matches all give the same pair
      write_order(1'b1);
      send_item(make_item(CMD_COMPOSE, '0, '0));
      send_item(make_item(CMD_CLEAR, '0, '0));
      settle();
   endtask

   // a few loads from a small value pool so that joins and repeats are common
   task automatic load_and_compose();
      logic [15:0] pool [4];
      int n_first;
      int n_second;
      foreach (pool[k]) pool[k] = 16'($urandom);
      n_first = ($urandom_range(9) == 0) ? $urandom_range(REL_DEPTH + 1) : $urandom_range(4);
      n_second = ($urandom_range(9) == 0) ? $urandom_range(REL_DEPTH + 1) : $urandom_range(4);
      if ($urandom_range(3) != 0)
         send_item(make_item(CMD_CLEAR, 16'($urandom), 16'($urandom)));
      repeat (n_first)
         send_item(make_item(CMD_LOAD_FIRST, pool[$urandom_range(3)], pool[$urandom_range(3)]));
      repeat (n_second)
         send_item(make_item(CMD_LOAD_SECOND, pool[$urandom_range(3)], pool[$urandom_range(3)]));
      send_item(make_item(CMD_COMPOSE, 16'($urandom), 16'($urandom)));
      if ($urandom_range(3) == 0)
         send_item(make_item(CMD_COMPOSE, 16'($urandom), 16'($urandom)));
   endtask

   task automatic random_phase(input int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(99) < 20)
            send_item(make_item(2'($urandom), 16'($urandom), 16'($urandom)));
         else
            load_and_compose();
      end
      settle();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      write_order(1'b0);
      directed_items();

      write_order(1'b1);
      random_phase(60);

      req_idle_pct = 61;
      rsp_idle_pct = 14;
      write_order(1'b0);
      random_phase(60);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_order(1'b1);
      random_phase(55);

      // anything arriving late is caught as unexpected
      repeat (20) @(negedge clock);
      $display("covered %0d items and %0d results, both orderings, with and without stalls",
               items_sent, board.checked);
      $display("seen %0d composed pairs, %0d empty sets, %0d dropped loads",
               board.pair_hits, board.empty_sets, board.dropped);
      if (board.mismatches == 0) begin
         $display("PASS relation_composition");
      end else begin
         $display("FAIL relation_composition");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("timeout with %0d items still owed", board.pending_results.size());
      $display("FAIL relation_composition");
      $finish;
   end

endmodule

>>> files.f
rtl/core/rc_pkg.sv
rtl/core/rc_rel_store.sv
rtl/core/rc_found.sv
rtl/core/relation_composition.sv
test/testbench.sv
